### sv/g6sd_pkg.sv
// Package for the graph6 stream decoder: item classes, result kinds,
// the command and result structs passed between the blocks, and constants.
// No dependencies.
package g6sd_pkg;

  localparam int unsigned SymBias    = 63;
  localparam int unsigned SymMax     = 126;
  localparam int unsigned HdrMax     = 125;
  localparam int unsigned BitsPerSym = 6;
  localparam int unsigned TopBit     = 5;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned BitW       = $clog2(BitsPerSym);

  typedef enum logic [1:0] {
    CLS_OK  = 2'd0,
    CLS_EXT = 2'd1,
    CLS_BAD = 2'd2
  } cls_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef struct packed {
    cls_e       cls;
    logic [5:0] val;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] count;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } result_t;

endpackage

### sv/g6sd_front.sv
// Front end of the graph6 stream decoder: classifies each character and
// holds the classified commands in a short queue for the back end.
// Depends on g6sd_pkg.
module g6sd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    symbol_i,
  output logic          cmd_valid_o,
  output g6sd_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  g6sd_pkg::cmd_t                    mem_q [g6sd_pkg::QueueDepth];
  logic [g6sd_pkg::PtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [g6sd_pkg::PtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [g6sd_pkg::CntW-1:0]         count_q, count_d;
  g6sd_pkg::cmd_t                    cmd_in;
  logic [7:0]                        sym_off;
  logic                              wr_en, rd_en;

  always_comb begin
    sym_off = symbol_i - 8'(g6sd_pkg::SymBias);
    cmd_in.val = sym_off[5:0];
    if (symbol_i < 8'(g6sd_pkg::SymBias) || symbol_i > 8'(g6sd_pkg::SymMax)) begin
      cmd_in.cls = g6sd_pkg::CLS_BAD;
    end else if (symbol_i > 8'(g6sd_pkg::HdrMax)) begin
      cmd_in.cls = g6sd_pkg::CLS_EXT;
    end else begin
      cmd_in.cls = g6sd_pkg::CLS_OK;
    end
  end

  assign full        = (count_q == g6sd_pkg::CntW'(g6sd_pkg::QueueDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr_en       = push & ~full;
  assign rd_en       = cmd_pop_i & cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### sv/g6sd_back.sv
// Back end of the graph6 stream decoder: holds the decoder state and emits results,
// walking the bits of a body character one per cycle unless the result queue is full.
// Depends on g6sd_pkg.
module g6sd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  g6sd_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output g6sd_pkg::result_t res_o
);

  // Current command.
  logic                    work_v_q, work_v_d;
  g6sd_pkg::cls_e          cls_q, cls_d;
  logic [5:0]              val_q, val_d;
  logic [g6sd_pkg::BitW-1:0] bit_q, bit_d;
  logic                    end_pend_q, end_pend_d;

  // Decoder state.
  logic                    in_body_q, in_body_d;
  logic [5:0]              order_q, order_d;
  logic [5:0]              row_q, row_d;
  logic [5:0]              col_q, col_d;

  // One result is held back until it is known whether it is the last of its item.
  logic                    held_v_q, held_v_d;
  logic                    held_last_q, held_last_d;
  g6sd_pkg::result_t       held_q, held_d;

  g6sd_pkg::result_t       new_res;
  logic                    new_v, done, go, act;
  logic [g6sd_pkg::BitW-1:0] bit_idx;
  logic [5:0]              row_inc, row_nx, col_nx;
  logic                    wrap, walk_end;

  assign go      = ~(held_v_q & res_full_i);
  assign act     = go & work_v_q;
  assign bit_idx = g6sd_pkg::BitW'(g6sd_pkg::TopBit) - bit_q;
  assign row_inc = row_q + 6'd1;
  assign wrap    = (row_inc >= col_q);
  assign row_nx  = wrap ? 6'd0 : row_inc;
  assign col_nx  = wrap ? col_q + 6'd1 : col_q;
  assign walk_end = (col_nx >= order_q);

  always_comb begin
    new_v        = 1'b0;
    done         = 1'b0;
    new_res      = '0;
    new_res.kind = g6sd_pkg::KIND_ERROR;
    in_body_d    = in_body_q;
    order_d      = order_q;
    row_d        = row_q;
    col_d        = col_q;
    bit_d        = bit_q;
    end_pend_d   = end_pend_q;

    if (end_pend_q) begin
      new_v         = 1'b1;
      new_res.kind  = g6sd_pkg::KIND_END;
      new_res.count = order_q;
      done          = 1'b1;
      end_pend_d    = 1'b0;
    end else if (!in_body_q) begin
      new_v = 1'b1;
      if (cls_q != g6sd_pkg::CLS_OK) begin
        new_res.kind = g6sd_pkg::KIND_ERROR;
        done         = 1'b1;
      end else begin
        new_res.kind  = g6sd_pkg::KIND_HEADER;
        new_res.count = val_q;
        order_d       = val_q;
        row_d         = 6'd0;
        col_d         = 6'd1;
        // Graphs of zero or one vertex have no body: the end follows at once.
        if (val_q < 6'd2) begin
          end_pend_d = 1'b1;
        end else begin
          in_body_d = 1'b1;
          done      = 1'b1;
        end
      end
    end else if (cls_q == g6sd_pkg::CLS_BAD) begin
      new_v         = 1'b1;
      new_res.kind  = g6sd_pkg::KIND_ERROR;
      new_res.count = order_q;
      in_body_d     = 1'b0;
      row_d         = 6'd0;
      col_d         = 6'd1;
      done          = 1'b1;
    end else begin
      new_v         = val_q[bit_idx];
      new_res.kind  = g6sd_pkg::KIND_EDGE;
      new_res.count = order_q;
      new_res.row   = row_q;
      new_res.col   = col_q;
      if (walk_end) begin
        // Remaining bits of this character are padding.
        in_body_d  = 1'b0;
        row_d      = 6'd0;
        col_d      = 6'd1;
        end_pend_d = 1'b1;
      end else begin
        row_d = row_nx;
        col_d = col_nx;
        if (bit_q == g6sd_pkg::BitW'(g6sd_pkg::TopBit)) begin
          done = 1'b1;
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end
    end
  end

  assign cmd_pop_o  = cmd_valid_i & (~work_v_q | (act & done));
  assign res_push_o = go & held_v_q & (held_last_q | (act & new_v));

  always_comb begin
    res_o      = held_q;
    res_o.last = held_last_q;
  end

  always_comb begin
    held_v_d    = held_v_q;
    held_last_d = held_last_q;
    held_d      = held_q;
    if (act && new_v) begin
      held_v_d    = 1'b1;
      held_d      = new_res;
      held_last_d = done;
    end else if (res_push_o) begin
      held_v_d = 1'b0;
    end else if (act && done) begin
      held_last_d = 1'b1;
    end

    work_v_d = work_v_q;
    cls_d    = cls_q;
    val_d    = val_q;
    if (cmd_pop_o) begin
      work_v_d = 1'b1;
      cls_d    = cmd_i.cls;
      val_d    = cmd_i.val;
    end else if (act && done) begin
      work_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_v_q    <= 1'b0;
      bit_q       <= '0;
      end_pend_q  <= 1'b0;
      in_body_q   <= 1'b0;
      order_q     <= 6'd0;
      row_q       <= 6'd0;
      col_q       <= 6'd1;
      held_v_q    <= 1'b0;
      held_last_q <= 1'b0;
    end else begin
      work_v_q    <= work_v_d;
      held_v_q    <= held_v_d;
      held_last_q <= held_last_d;
      if (cmd_pop_o) begin
        bit_q      <= '0;
        end_pend_q <= 1'b0;
      end else if (act) begin
        bit_q      <= bit_d;
        end_pend_q <= end_pend_d;
      end
      if (act) begin
        in_body_q <= in_body_d;
        order_q   <= order_d;
        row_q     <= row_d;
        col_q     <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q  <= cls_d;
    val_q  <= val_d;
    held_q <= held_d;
  end

endmodule

### sv/g6sd_result_queue.sv
// Result queue of the graph6 stream decoder: a short queue of result
// items between the back end and the output ports.
// Depends on g6sd_pkg.
module g6sd_result_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  g6sd_pkg::result_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output g6sd_pkg::result_t data_o
);

  g6sd_pkg::result_t           mem_q [g6sd_pkg::QueueDepth];
  logic [g6sd_pkg::PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [g6sd_pkg::PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [g6sd_pkg::CntW-1:0]   count_q, count_d;
  logic                        wr_en, rd_en;

  assign full_o  = (count_q == g6sd_pkg::CntW'(g6sd_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/graph6_stream_decoder_unit.sv
// Graph6 stream decoder for graphs of up to 62 vertices. A header character
// yields a header result (and then an end result for fewer than two
// vertices); a bad character gives an error result. Each body character is
// walked one bit per cycle unless a full result queue holds it up; when the
// graph ends in it, the walk stops after the last pair and an end result
// follows. At most one result is produced per cycle. The bit walk in the back
// end sets the rate; a four-entry queue on each side lets characters be taken
// and results drained while it works.
// Depends on g6sd_pkg, g6sd_front, g6sd_back and g6sd_result_queue.
module graph6_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] result_kind_o,
  output logic [5:0] vertex_count_o,
  output logic [5:0] edge_row_o,
  output logic [5:0] edge_column_o,
  output logic       last_o
);

  g6sd_pkg::cmd_t    cmd;
  logic              cmd_valid, cmd_pop;
  g6sd_pkg::result_t res_in, res_out;
  logic              res_push, res_full;

  g6sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .symbol_i    (symbol_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  g6sd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  g6sd_result_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign result_kind_o  = res_out.kind;
  assign vertex_count_o = res_out.count;
  assign edge_row_o     = res_out.row;
  assign edge_column_o  = res_out.col;
  assign last_o         = res_out.last;

endmodule

### tb/graph6_stream_decoder_unit_tb.sv
// Self-checking testbench for graph6_stream_decoder_unit: it streams graph6 characters,
// decodes them again in a behavioural model and compares every result transfer.
// Depends on g6sd_pkg and the decoder RTL.
module graph6_stream_decoder_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] symbol_i = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] result_kind_o;
  logic [5:0] vertex_count_o;
  logic [5:0] edge_row_o;
  logic [5:0] edge_column_o;
  logic       last_o;

  graph6_stream_decoder_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .symbol_i       (symbol_i),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind_o),
    .vertex_count_o (vertex_count_o),
    .edge_row_o     (edge_row_o),
    .edge_column_o  (edge_column_o),
    .last_o         (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder model state.
  logic       in_graph_body = 1'b0;
  logic [5:0] graph_order = 6'd0;
  logic [5:0] pair_row = 6'd0;
  logic [5:0] pair_col = 6'd1;

  g6sd_pkg::result_t decoded_results[$];

  int unsigned error_count = 0;
  int unsigned symbols_sent = 0;
  int unsigned edges_seen = 0;
  int unsigned graphs_ended = 0;
  int unsigned errors_seen = 0;
  int unsigned stall_cycles = 0;
  bit          sender_no_idle = 1'b0;
  bit          drain_no_idle = 1'b0;

  function automatic g6sd_pkg::result_t make_result(g6sd_pkg::kind_e kind,
                                                    logic [5:0] count,
                                                    logic [5:0] row, logic [5:0] col);
    g6sd_pkg::result_t r;
    r.kind  = kind;
    r.count = count;
    r.row   = row;
    r.col   = col;
    r.last  = 1'b0;
    return r;
  endfunction

  // Work out every result that one accepted character produces.
  task automatic decode_symbol(input logic [7:0] sym);
    g6sd_pkg::result_t batch[7];
    int                k;
    logic [5:0]        bits;
    bit                walk_done;
    k = 0;
    walk_done = 1'b0;
    if (!in_graph_body) begin
      if (sym < g6sd_pkg::SymBias || sym > g6sd_pkg::HdrMax) begin
        batch[k++] = make_result(g6sd_pkg::KIND_ERROR, 6'd0, 6'd0, 6'd0);
      end else begin
        graph_order = 6'(sym - g6sd_pkg::SymBias);
        pair_row = 6'd0;
        pair_col = 6'd1;
        batch[k++] = make_result(g6sd_pkg::KIND_HEADER, graph_order, 6'd0, 6'd0);
        if (graph_order < 6'd2) begin
          batch[k++] = make_result(g6sd_pkg::KIND_END, graph_order, 6'd0, 6'd0);
        end else begin
          in_graph_body = 1'b1;
        end
      end
    end else if (sym < g6sd_pkg::SymBias || sym > g6sd_pkg::SymMax) begin
      batch[k++] = make_result(g6sd_pkg::KIND_ERROR, graph_order, 6'd0, 6'd0);
      in_graph_body = 1'b0;
      pair_row = 6'd0;
      pair_col = 6'd1;
    end else begin
      bits = 6'(sym - g6sd_pkg::SymBias);
      for (int i = 0; i < g6sd_pkg::BitsPerSym; i++) begin
        if (!walk_done) begin
          if (bits[g6sd_pkg::TopBit - i]) begin
            batch[k++] = make_result(g6sd_pkg::KIND_EDGE, graph_order, pair_row, pair_col);
          end
          pair_row = pair_row + 6'd1;
          if (pair_row >= pair_col) begin
            pair_row = 6'd0;
            pair_col = pair_col + 6'd1;
          end
          // Once the last pair is walked, the remaining bits are padding.
          if (pair_col >= graph_order) begin
            batch[k++] = make_result(g6sd_pkg::KIND_END, graph_order, 6'd0, 6'd0);
            in_graph_body = 1'b0;
            pair_row = 6'd0;
            pair_col = 6'd1;
            walk_done = 1'b1;
          end
        end
      end
    end
    if (k > 0) begin
      batch[k - 1].last = 1'b1;
    end
    for (int i = 0; i < k; i++) begin
      decoded_results.push_back(batch[i]);
    end
  endtask

  // Offer one character after a random gap and hold it until the transfer.
  task automatic send_symbol(input logic [7:0] sym);
    int gap;
    gap = sender_no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    symbol_i <= sym;
    do @(posedge clk_i); while (full);
    decode_symbol(sym);
    symbols_sent++;
  endtask

  // Hold the sender off until every outstanding result has been drained.
  task automatic wait_drained();
    push <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] bad_symbol();
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, g6sd_pkg::SymBias - 1));
    end
    return 8'($urandom_range(g6sd_pkg::SymMax + 1, 255));
  endfunction

  // One graph with random body content; optionally cut short by a bad character.
  task automatic send_graph(input int unsigned order, input bit broken);
    int unsigned body_chars;
    int unsigned break_at;
    body_chars = (order * (order - 1) / 2 + g6sd_pkg::BitsPerSym - 1) /
                 g6sd_pkg::BitsPerSym;
    break_at = (body_chars > 0) ? $urandom_range(0, body_chars - 1) : 0;
    send_symbol(8'(g6sd_pkg::SymBias + order));
    for (int unsigned i = 0; i < body_chars; i++) begin
      if (broken && i == break_at) begin
        send_symbol(bad_symbol());
        return;
      end
      send_symbol(8'($urandom_range(g6sd_pkg::SymBias, g6sd_pkg::SymMax)));
    end
  endtask

  task automatic test_small_orders();
    send_symbol(8'd63);
    send_symbol(8'd64);
    send_symbol(8'd65);
    send_symbol(8'd126);
    send_symbol(8'd66);
    send_symbol(8'd119);
    send_symbol(8'd66);
    send_symbol(8'd63);
    wait_drained();
  endtask

  task automatic test_full_characters();
    // Four vertices use exactly six bits, so one character gives the most results.
    send_symbol(8'd67);
    send_symbol(8'd126);
    send_symbol(8'd69);
    send_symbol(8'd126);
    send_symbol(8'd126);
    send_symbol(8'd126);
  endtask

  task automatic test_bad_headers();
    send_symbol(8'd126);
    send_symbol(8'd0);
    send_symbol(8'd255);
    send_symbol(8'd62);
    send_symbol(8'd127);
  endtask

  task automatic test_bad_body();
    send_symbol(8'd68);
    send_symbol(8'd126);
    send_symbol(8'd255);
    send_symbol(8'd68);
    send_symbol(8'd62);
    send_symbol(8'd125);
    send_symbol(8'd126);
    send_symbol(8'd0);
    wait_drained();
  endtask

  // The largest order: a header, a few body characters, then a bad character.
  task automatic test_largest_order();
    send_symbol(8'd125);
    repeat (8) send_symbol(8'($urandom_range(g6sd_pkg::SymBias, g6sd_pkg::SymMax)));
    send_symbol(bad_symbol());
    wait_drained();
  endtask

  task automatic test_random_stream();
    int unsigned target;
    int unsigned pick;
    bit          drained_once;
    target = symbols_sent + 185;
    drained_once = 1'b0;
    while (symbols_sent < target) begin
      sender_no_idle = ($urandom_range(0, 3) == 0);
      drain_no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_graph($urandom_range(13, 30), $urandom_range(0, 6) == 0);
      end else if (pick < 8) begin
        send_graph($urandom_range(0, 12), $urandom_range(0, 6) == 0);
      end else if (pick == 8) begin
        send_symbol(8'($urandom_range(0, 255)));
      end else begin
        send_symbol($urandom_range(0, 1) ? 8'(g6sd_pkg::SymMax) : bad_symbol());
      end
      if (!drained_once && symbols_sent > target - 90) begin
        wait_drained();
        drained_once = 1'b1;
      end
    end
    sender_no_idle = 1'b0;
    drain_no_idle = 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result side: random stalls, then compare each transfer with the oldest expectation.
  initial begin : result_checker
    int                gap;
    g6sd_pkg::result_t want;
    wait (rst_ni);
    forever begin
      gap = drain_no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (decoded_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d count %0d row %0d col %0d", $time,
                 result_kind_o, vertex_count_o, edge_row_o, edge_column_o);
        error_count++;
      end else begin
        want = decoded_results.pop_front();
        check_field("result_kind", want.kind, result_kind_o);
        check_field("vertex_count", want.count, vertex_count_o);
        check_field("edge_row", want.row, edge_row_o);
        check_field("edge_column", want.col, edge_column_o);
        check_field("last", want.last, last_o);
        case (want.kind)
          g6sd_pkg::KIND_EDGE:  edges_seen++;
          g6sd_pkg::KIND_END:   graphs_ended++;
          g6sd_pkg::KIND_ERROR: errors_seen++;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_orders();
    test_full_characters();
    test_bad_headers();
    test_bad_body();
    test_largest_order();
    test_random_stream();
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("Streamed %0d characters: %0d graphs closed, %0d edges, %0d error results.",
             symbols_sent, graphs_ended, edges_seen, errors_seen);
    $display("Whole graphs of up to 30 vertices, an order-62 header, padding,");
    $display("extended-size and out-of-range characters exercised.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/g6sd_pkg.sv
sv/g6sd_front.sv
sv/g6sd_back.sv
sv/g6sd_result_queue.sv
sv/graph6_stream_decoder_unit.sv
tb/graph6_stream_decoder_unit_tb.sv
